// ----- hdl/pnt_pkg.sv -----
package pnt_pkg;

    localparam int POS_W  = 32;
    localparam int GRAD_W = 16;
    localparam int PERM_W = 8;
    localparam int IDX_W  = 8;
    localparam int OUT_W  = 20;
    localparam int CFG_W  = 4;
    localparam int OCT_W  = 5;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_NOISE = 2'd1;
    localparam logic [1:0] REQ_TURB  = 2'd2;

    typedef struct packed {
        logic             cap;
        logic             t2;
        logic             sm;
        logic             hash;
        logic             grad;
        logic             dot;
        logic             mul;
        logic             acc;
        logic             oct;
        logic             fin;
        logic             turb;
        logic [2:0]       corner;
        logic [OCT_W-1:0] octave;
    } t_cmd;

endpackage

// ----- hdl/pnt_ram.sv -----
module pnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/pnt_ctrl.sv -----
module pnt_ctrl #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_req_type,
    input  logic [pnt_pkg::CFG_W-1:0] i_octaves,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output pnt_pkg::t_cmd             o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_SM1  = 11'b00000000010,
        S_SM2  = 11'b00000000100,
        S_ADDR = 11'b00000001000,
        S_HASH = 11'b00000010000,
        S_GRAD = 11'b00000100000,
        S_DOT  = 11'b00001000000,
        S_MUL  = 11'b00010000000,
        S_ACC  = 11'b00100000000,
        S_OCT  = 11'b01000000000,
        S_FIN  = 11'b10000000000
    } t_state;

    localparam logic [pnt_pkg::OCT_W-1:0] MO = pnt_pkg::OCT_W'(MAX_OCTAVES);

    t_state                    r_state, n_state;
    logic [2:0]                r_corner, n_corner;
    logic [pnt_pkg::OCT_W-1:0] r_oct, n_oct;
    logic [pnt_pkg::OCT_W-1:0] r_nocts, n_nocts;
    logic                      r_turb, n_turb;
    logic                      r_out_valid, n_out_valid;
    logic [pnt_pkg::OCT_W-1:0] oct_cfg;
    logic                      accept;
    logic                      out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign oct_cfg    = (pnt_pkg::OCT_W'(i_octaves) > MO) ? MO : pnt_pkg::OCT_W'(i_octaves);

    always_comb begin
        n_state     = r_state;
        n_corner    = r_corner;
        n_oct       = r_oct;
        n_nocts     = r_nocts;
        n_turb      = r_turb;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd        = '0;
        o_cmd.corner = r_corner;
        o_cmd.octave = r_oct;
        o_cmd.turb   = r_turb;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_req_type == pnt_pkg::REQ_NOISE ||
                               i_req_type == pnt_pkg::REQ_TURB)) begin
                    o_cmd.cap = 1'b1;
                    n_oct     = '0;
                    n_turb    = (i_req_type == pnt_pkg::REQ_TURB);
                    n_nocts   = (i_req_type == pnt_pkg::REQ_TURB) ? oct_cfg
                                                                  : pnt_pkg::OCT_W'(1);
                    if (i_req_type == pnt_pkg::REQ_TURB && oct_cfg == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SM1;
                    end
                end
            end
            S_SM1: begin
                o_cmd.t2 = 1'b1;
                n_state  = S_SM2;
            end
            S_SM2: begin
                o_cmd.sm = 1'b1;
                n_corner = '0;
                n_state  = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_HASH;
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = S_GRAD;
            end
            S_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = S_DOT;
            end
            S_DOT: begin
                o_cmd.dot = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_corner == 3'd7) begin
                    n_state = S_OCT;
                end else begin
                    n_corner = r_corner + 3'd1;
                    n_state  = S_ADDR;
                end
            end
            S_OCT: begin
                o_cmd.oct = 1'b1;
                n_oct     = r_oct + pnt_pkg::OCT_W'(1);
                if (r_oct + pnt_pkg::OCT_W'(1) == r_nocts) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SM1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_corner    <= '0;
            r_oct       <= '0;
            r_nocts     <= '0;
            r_turb      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_corner    <= n_corner;
            r_oct       <= n_oct;
            r_nocts     <= n_nocts;
            r_turb      <= n_turb;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_oct_after_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OCT) |-> (r_corner == 3'd7))
        else $error("octave closed before all corners");

    a_oct_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OCT) |-> (r_oct < r_nocts))
        else $error("octave count overrun");

    a_fin_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> out_free)
        else $error("result overwritten");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result dropped");

endmodule

// ----- hdl/pnt_dp.sv -----
module pnt_dp #(
    parameter int TABLE_SIZE  = 256,
    parameter int FRAC_BITS   = 16,
    parameter int MAX_OCTAVES = 8
) (
    input  logic                              i_clk,
    input  pnt_pkg::t_cmd                     i_cmd,
    input  logic signed [pnt_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [pnt_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [pnt_pkg::POS_W-1:0]  i_pos_z,
    output logic [$clog2(TABLE_SIZE)-1:0]     o_perm_addr_x,
    output logic [$clog2(TABLE_SIZE)-1:0]     o_perm_addr_y,
    output logic [$clog2(TABLE_SIZE)-1:0]     o_perm_addr_z,
    input  logic [pnt_pkg::PERM_W-1:0]        i_perm_x,
    input  logic [pnt_pkg::PERM_W-1:0]        i_perm_y,
    input  logic [pnt_pkg::PERM_W-1:0]        i_perm_z,
    output logic [$clog2(TABLE_SIZE)-1:0]     o_grad_addr,
    input  logic [3*pnt_pkg::GRAD_W-1:0]      i_grad,
    output logic signed [pnt_pkg::OUT_W-1:0]  o_result
);

    localparam int F  = FRAC_BITS;
    localparam int IW = $clog2(TABLE_SIZE);
    localparam int GW = pnt_pkg::GRAD_W;
    localparam int NW = 24;
    localparam int TW = NW + MAX_OCTAVES + 1;
    localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
    localparam logic [F:0]   ONE       = (F+1)'(1) << F;
    localparam logic signed [TW-1:0] OUT_MAX = TW'(524287);
    localparam logic signed [TW-1:0] OUT_MIN = -TW'(524288);

    logic signed [pnt_pkg::POS_W-1:0] r_pos [3];
    logic [IW-1:0]                    r_cell [3];
    logic [F-1:0]                     r_t2 [3];
    logic [F:0]                       r_s [3];
    logic signed [GW+F:0]             r_pr [3];
    logic [F:0]                       r_wxy;
    logic [F:0]                       r_w;
    logic signed [18:0]               r_dq;
    logic signed [F+20:0]             r_prod;
    logic signed [F+23:0]             r_acc;
    logic signed [TW-1:0]             r_turb;
    logic signed [pnt_pkg::OUT_W-1:0] r_result;

    logic [F-1:0]             t [3];
    logic                     cb [3];
    logic signed [F:0]        offs [3];
    logic [F:0]               wsel [3];
    logic signed [GW-1:0]     g [3];
    logic [2*F-1:0]           t2p [3];
    logic [F+1:0]             mval [3];
    logic [2*F+1:0]           sp [3];
    logic signed [pnt_pkg::POS_W-1:0] cell_full [3];
    logic [2*F+1:0]           wxy_p;
    logic [2*F+1:0]           w_p;
    logic signed [F+18:0]     dsum;
    logic signed [F+18:0]     dsh;
    logic signed [F+23:0]     ash;
    logic signed [NW-1:0]     noise;
    logic signed [TW-1:0]     nse;
    logic [pnt_pkg::OCT_W-1:0] shamt;
    logic signed [TW-1:0]     tsh;
    logic signed [TW-1:0]     tabs;
    logic [pnt_pkg::PERM_W-1:0] hx;

    assign g[0] = $signed(i_grad[3*GW-1:2*GW]);
    assign g[1] = $signed(i_grad[2*GW-1:GW]);
    assign g[2] = $signed(i_grad[GW-1:0]);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            t[a]         = r_pos[a][F-1:0];
            cb[a]        = i_cmd.corner[2-a];
            offs[a]      = cb[a] ? $signed({1'b1, t[a]}) : $signed({1'b0, t[a]});
            wsel[a]      = cb[a] ? r_s[a] : ONE - r_s[a];
            t2p[a]       = {{F{1'b0}}, t[a]} * {{F{1'b0}}, t[a]};
            mval[a]      = THREE_ONE - {1'b0, t[a], 1'b0};
            sp[a]        = {{(F+2){1'b0}}, r_t2[a]} * {{F{1'b0}}, mval[a]};
            cell_full[a] = r_pos[a] >>> F;
        end
    end

    assign o_perm_addr_x = r_cell[0] + IW'(cb[0]);
    assign o_perm_addr_y = r_cell[1] + IW'(cb[1]);
    assign o_perm_addr_z = r_cell[2] + IW'(cb[2]);
    assign hx            = i_perm_x ^ i_perm_y ^ i_perm_z;
    assign o_grad_addr   = IW'(hx);

    assign wxy_p = {{(F+1){1'b0}}, wsel[0]} * {{(F+1){1'b0}}, wsel[1]};
    assign w_p   = {{(F+1){1'b0}}, r_wxy} * {{(F+1){1'b0}}, wsel[2]};
    assign dsum  = (F+19)'(r_pr[0]) + (F+19)'(r_pr[1]) + (F+19)'(r_pr[2]);
    assign dsh   = dsum >>> F;
    assign ash   = r_acc >>> F;
    assign noise = ash[NW-1:0];
    assign nse   = TW'(noise);
    assign shamt = pnt_pkg::OCT_W'(MAX_OCTAVES - 1) - i_cmd.octave;
    assign tsh   = r_turb >>> (MAX_OCTAVES - 1);
    assign tabs  = (i_cmd.turb && tsh < 0) ? -tsh : tsh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_turb   <= '0;
        end
        if (i_cmd.t2) begin
            for (int a = 0; a < 3; a++) begin
                r_t2[a]   <= t2p[a][2*F-1:F];
                r_cell[a] <= cell_full[a][IW-1:0];
            end
            r_acc <= '0;
        end
        if (i_cmd.sm) begin
            for (int a = 0; a < 3; a++) begin
                r_s[a] <= sp[a][2*F:F];
            end
        end
        if (i_cmd.hash) begin
            r_wxy <= wxy_p[2*F:F];
        end
        if (i_cmd.grad) begin
            for (int a = 0; a < 3; a++) begin
                r_pr[a] <= (GW+F+1)'(g[a]) * (GW+F+1)'(offs[a]);
            end
            r_w <= w_p[2*F:F];
        end
        if (i_cmd.dot) begin
            r_dq <= dsh[18:0];
        end
        if (i_cmd.mul) begin
            r_prod <= (F+21)'(r_dq) * (F+21)'($signed({1'b0, r_w}));
        end
        if (i_cmd.acc) begin
            r_acc <= r_acc + (F+24)'(r_prod);
        end
        if (i_cmd.oct) begin
            r_turb <= r_turb + (nse <<< shamt);
            for (int a = 0; a < 3; a++) begin
                r_pos[a] <= r_pos[a] <<< 1;
            end
        end
        if (i_cmd.fin) begin
            if (tabs > OUT_MAX) begin
                r_result <= OUT_MAX[pnt_pkg::OUT_W-1:0];
            end else if (tabs < OUT_MIN) begin
                r_result <= OUT_MIN[pnt_pkg::OUT_W-1:0];
            end else begin
                r_result <= tabs[pnt_pkg::OUT_W-1:0];
            end
        end
    end

    assign o_result = r_result;

endmodule

// ----- hdl/perlin_noise_turbulence.sv -----
// 3d gradient noise and turbulence engine. a load request (type 0) writes one entry of the
// three permutation tables and the gradient table when it is accepted and gives no result; a
// noise request (type 1) covers one octave and a turbulence request (type 2) covers the
// octaves one after another, with the octave count from the cfg register clamped to
// MAX_OCTAVES. the eight lattice corners of each octave are visited one after another
// through the shared hash lookup, dot product and weight multiply, and that loop sets the
// rate. one request is worked on at a time; a finished result waits in the output register
// while the next request is accepted. tables are not cleared at reset and must be loaded
// before use.
module perlin_noise_turbulence #(
    parameter int TABLE_SIZE  = 256,
    parameter int FRAC_BITS   = 16,
    parameter int MAX_OCTAVES = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_req_type,
    input  logic [pnt_pkg::IDX_W-1:0]          i_table_index,
    input  logic [pnt_pkg::PERM_W-1:0]         i_perm_x_value,
    input  logic [pnt_pkg::PERM_W-1:0]         i_perm_y_value,
    input  logic [pnt_pkg::PERM_W-1:0]         i_perm_z_value,
    input  logic signed [pnt_pkg::GRAD_W-1:0]  i_grad_x,
    input  logic signed [pnt_pkg::GRAD_W-1:0]  i_grad_y,
    input  logic signed [pnt_pkg::GRAD_W-1:0]  i_grad_z,
    input  logic signed [pnt_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [pnt_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [pnt_pkg::POS_W-1:0]   i_pos_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pnt_pkg::OUT_W-1:0]   o_noise_value,
    input  logic                               i_cfg_we,
    input  logic [pnt_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int IW = $clog2(TABLE_SIZE);

    logic [pnt_pkg::CFG_W-1:0]   r_octaves;
    pnt_pkg::t_cmd               cmd;
    logic                        we;
    logic [IW-1:0]               waddr;
    logic [IW-1:0]               pa_x, pa_y, pa_z, ga;
    logic [pnt_pkg::PERM_W-1:0]  pd_x, pd_y, pd_z;
    logic [3*pnt_pkg::GRAD_W-1:0] gd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octaves <= pnt_pkg::CFG_W'(7);
        end else if (i_cfg_we) begin
            r_octaves <= i_cfg_data;
        end
    end

    assign we    = i_in_valid && o_in_ready && (i_req_type == pnt_pkg::REQ_LOAD);
    assign waddr = IW'(i_table_index);

    pnt_ram #(.WIDTH(pnt_pkg::PERM_W), .DEPTH(TABLE_SIZE)) u_perm_x (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_perm_x_value),
        .i_raddr(pa_x), .o_rdata(pd_x)
    );

    pnt_ram #(.WIDTH(pnt_pkg::PERM_W), .DEPTH(TABLE_SIZE)) u_perm_y (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_perm_y_value),
        .i_raddr(pa_y), .o_rdata(pd_y)
    );

    pnt_ram #(.WIDTH(pnt_pkg::PERM_W), .DEPTH(TABLE_SIZE)) u_perm_z (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_perm_z_value),
        .i_raddr(pa_z), .o_rdata(pd_z)
    );

    pnt_ram #(.WIDTH(3*pnt_pkg::GRAD_W), .DEPTH(TABLE_SIZE)) u_grad (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr),
        .i_wdata({i_grad_x, i_grad_y, i_grad_z}),
        .i_raddr(ga), .o_rdata(gd)
    );

    pnt_ctrl #(.MAX_OCTAVES(MAX_OCTAVES)) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_req_type(i_req_type),
        .i_octaves(r_octaves),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd(cmd)
    );

    pnt_dp #(
        .TABLE_SIZE(TABLE_SIZE),
        .FRAC_BITS(FRAC_BITS),
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_dp (
        .i_clk(i_clk),
        .i_cmd(cmd),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z),
        .o_perm_addr_x(pa_x),
        .o_perm_addr_y(pa_y),
        .o_perm_addr_z(pa_z),
        .i_perm_x(pd_x),
        .i_perm_y(pd_y),
        .i_perm_z(pd_z),
        .o_grad_addr(ga),
        .i_grad(gd),
        .o_result(o_noise_value)
    );

endmodule

// ----- sim/perlin_noise_turbulence_tb.sv -----
module perlin_noise_turbulence_tb;

    localparam int ONE_F   = 1 << 16;
    localparam int MAX_OCT = 8;
    localparam int LIMIT   = 20000;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  in_ready;
    logic [1:0]                            req_type = pnt_pkg::REQ_LOAD;
    logic [pnt_pkg::IDX_W-1:0]             table_index = '0;
    logic [pnt_pkg::PERM_W-1:0]            perm_x = '0, perm_y = '0, perm_z = '0;
    logic signed [pnt_pkg::GRAD_W-1:0]     grad_x = '0, grad_y = '0, grad_z = '0;
    logic signed [pnt_pkg::POS_W-1:0]      pos_x = '0, pos_y = '0, pos_z = '0;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic signed [pnt_pkg::OUT_W-1:0]      noise_value;
    logic                                  cfg_we = 1'b0;
    logic [pnt_pkg::CFG_W-1:0]             cfg_data = '0;

    int idle_cycles = 0;
    bit in_done = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    perlin_noise_turbulence u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_req_type(req_type), .i_table_index(table_index),
        .i_perm_x_value(perm_x), .i_perm_y_value(perm_y), .i_perm_z_value(perm_z),
        .i_grad_x(grad_x), .i_grad_y(grad_y), .i_grad_z(grad_z),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_noise_value(noise_value),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    class noise_scoreboard;
        logic [7:0]                    px_tab [256];
        logic [7:0]                    py_tab [256];
        logic [7:0]                    pz_tab [256];
        logic signed [15:0]            g_tab [256][3];
        logic [3:0]                    octaves = 4'd7;
        logic [pnt_pkg::OUT_W-1:0]     pending [$];
        bit                            failed = 0;

        function longint fshift(longint x, int s);
            return x >>> s;
        endfunction

        function longint smooth(longint t);
            longint t2;
            t2 = (t * t) >>> 16;
            return (t2 * (3 * ONE_F - 2 * t)) >>> 16;
        endfunction

        function longint lattice_noise(logic [31:0] p [3]);
            longint lat [3], frac [3], sw [3];
            longint acc, dot, w, wx, wy, wz;
            logic [7:0] ix, iy, iz, h;
            acc = 0;
            for (int a = 0; a < 3; a++) begin
                lat[a] = longint'($signed(p[a])) >>> 16;
                frac[a] = longint'(p[a][15:0]);
                sw[a] = smooth(frac[a]);
            end
            for (int di = 0; di < 2; di++)
                for (int dj = 0; dj < 2; dj++)
                    for (int dk = 0; dk < 2; dk++) begin
                        ix = 8'(lat[0] + di);
                        iy = 8'(lat[1] + dj);
                        iz = 8'(lat[2] + dk);
                        h = px_tab[ix] ^ py_tab[iy] ^ pz_tab[iz];
                        dot = longint'(g_tab[h][0]) * (frac[0] - di * ONE_F)
                            + longint'(g_tab[h][1]) * (frac[1] - dj * ONE_F)
                            + longint'(g_tab[h][2]) * (frac[2] - dk * ONE_F);
                        wx = di ? sw[0] : ONE_F - sw[0];
                        wy = dj ? sw[1] : ONE_F - sw[1];
                        wz = dk ? sw[2] : ONE_F - sw[2];
                        w = (((wx * wy) >>> 16) * wz) >>> 16;
                        acc += fshift(dot, 16) * w;
                    end
            return fshift(acc, 16);
        endfunction

        function logic [pnt_pkg::OUT_W-1:0] clip(longint v);
            if (v > 524287) v = 524287;
            if (v < -524288) v = -524288;
            return pnt_pkg::OUT_W'(v);
        endfunction

        function void note_request(logic [1:0] rt, logic [7:0] k, logic [7:0] vx,
                                   logic [7:0] vy, logic [7:0] vz, logic [15:0] gx,
                                   logic [15:0] gy, logic [15:0] gz, logic [31:0] p [3]);
            longint acc;
            int n;
            if (rt == pnt_pkg::REQ_LOAD) begin
                px_tab[k] = vx; py_tab[k] = vy; pz_tab[k] = vz;
                g_tab[k][0] = gx; g_tab[k][1] = gy; g_tab[k][2] = gz;
            end else if (rt == pnt_pkg::REQ_NOISE) begin
                pending.push_back(clip(lattice_noise(p)));
            end else if (rt == pnt_pkg::REQ_TURB) begin
                n = (octaves > MAX_OCT) ? MAX_OCT : octaves;
                acc = 0;
                for (int i = 0; i < n; i++) begin
                    acc += lattice_noise(p) * (longint'(1) << (MAX_OCT - 1 - i));
                    for (int a = 0; a < 3; a++) p[a] = p[a] << 1;
                end
                acc = fshift(acc, MAX_OCT - 1);
                if (acc < 0) acc = -acc;
                pending.push_back(clip(acc));
            end
        endfunction

        function void check_result(logic [pnt_pkg::OUT_W-1:0] got);
            logic [pnt_pkg::OUT_W-1:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d", $time,
                         $signed(got));
                failed = 1;
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    $display("%0t: noise_value expected %0d actual %0d", $time,
                             $signed(want), $signed(got));
                    failed = 1;
                end
            end
        endfunction
    endclass

    noise_scoreboard sb = new();

    // sample at rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                logic [31:0] p [3];
                p[0] = pos_x; p[1] = pos_y; p[2] = pos_z;
                sb.note_request(req_type, table_index, perm_x, perm_y, perm_z,
                                grad_x, grad_y, grad_z, p);
            end
            if (out_valid && out_ready) sb.check_result(noise_value);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // result side back-pressure
    initial begin
        int w;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (w > 0) begin
                out_ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // valid stays high after acceptance until the next call or input_idle
    task automatic send_request(logic [1:0] rt, logic [7:0] k, logic [7:0] vx,
                                logic [7:0] vy, logic [7:0] vz, logic [15:0] gx,
                                logic [15:0] gy, logic [15:0] gz, logic [31:0] x,
                                logic [31:0] y, logic [31:0] z);
        int w;
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (w > 0) begin
            in_valid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt; table_index <= k;
        perm_x <= vx; perm_y <= vy; perm_z <= vz;
        grad_x <= gx; grad_y <= gy; grad_z <= gz;
        pos_x <= x; pos_y <= y; pos_z <= z;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic input_idle();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_entry(logic [7:0] k);
        send_request(pnt_pkg::REQ_LOAD, k, 8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 0, 0, 0);
    endtask

    // only positions whose 8 corners and every reachable hash are loaded
    task automatic send_eval(logic [1:0] rt, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        send_request(rt, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), x, y, z);
    endtask

    task automatic drain_and_config(logic [3:0] v);
        input_idle();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.octaves = v;
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return {16'($urandom), 16'hffff};
            3: return {16'($urandom), 16'h0000};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_grad();
        case ($urandom_range(0, 4))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    initial begin
        logic [3:0] oct_set [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd7};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: full table with extreme entries first
        send_request(pnt_pkg::REQ_LOAD, 8'd0, 8'd0, 8'd255, 8'd0, 16'sd16384,
                     -16'sd16384, 16'h8000, 0, 0, 0);
        send_request(pnt_pkg::REQ_LOAD, 8'd255, 8'd255, 8'd0, 8'd255, 16'h7fff,
                     16'h8000, -16'sd16384, 0, 0, 0);
        send_request(2'd3, 8'd5, 8'd1, 8'd1, 8'd1, 16'd1, 16'd1, 16'd1, 0, 0, 0);
        for (int k = 1; k < 255; k++)
            send_request(pnt_pkg::REQ_LOAD, 8'(k), 8'($urandom), 8'($urandom),
                         8'($urandom), rand_grad(), rand_grad(), rand_grad(), 0, 0, 0);
        send_eval(pnt_pkg::REQ_NOISE, 0, 0, 0);
        send_eval(pnt_pkg::REQ_NOISE, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_eval(pnt_pkg::REQ_NOISE, 32'h0000_8000, 32'h0000_ffff, 32'h0001_0000);
        send_eval(pnt_pkg::REQ_TURB, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_eval(pnt_pkg::REQ_TURB, 32'h8000_0000, 32'h0, 32'hffff_ffff);
        send_eval(2'd3, 32'h1234_5678, 0, 0);
        // random phases across octave settings
        foreach (oct_set[s]) begin
            drain_and_config(oct_set[s]);
            for (int i = 0; i < 220; i++) begin
                case ($urandom_range(0, 9))
                    0: send_request(pnt_pkg::REQ_LOAD, 8'($urandom), 8'($urandom),
                                    8'($urandom), 8'($urandom), rand_grad(), rand_grad(),
                                    rand_grad(), 0, 0, 0);
                    1: send_eval(2'd3, $urandom, $urandom, $urandom);
                    2, 3, 4, 5: send_eval(pnt_pkg::REQ_NOISE, rand_pos(), rand_pos(),
                                          rand_pos());
                    default: send_eval(pnt_pkg::REQ_TURB, rand_pos(), rand_pos(),
                                       rand_pos());
                endcase
            end
        end
        input_idle();
        in_done = 1;
    end

    initial begin
        wait (in_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (!sb.failed && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= LIMIT);
        $display("Timeout after %0d idle cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
    end
endmodule

// ----- perlin_noise_turbulence.f -----
hdl/pnt_pkg.sv
hdl/pnt_ram.sv
hdl/pnt_ctrl.sv
hdl/pnt_dp.sv
hdl/perlin_noise_turbulence.sv
sim/perlin_noise_turbulence_tb.sv
